FILE: rtl/fcar_pkg.sv
`default_nettype none

package fcar_pkg;

    localparam logic [7:0] START_MARK = 8'h21;
    localparam logic [7:0] END_MARK = 8'h23;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [15:0] RETRY_RESET = 16'd3000;
    localparam logic [2:0] LEN_SAT = 3'd4;
    localparam logic [3:0] HEAD_LEN = 4'd5;

    typedef logic [11:0] sample_t;
    typedef logic [3:0] bcd_t;
    typedef logic [3:0] pos_t;

    typedef enum logic {
        LINK_IDLE = 1'b0,
        LINK_WAIT_OK = 1'b1
    } link_state_t;

    typedef enum logic {
        REG_RETRY_TICKS = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic load;
        sample_t sample;
    } emit_req_t;

    function automatic logic [7:0] head_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = 8'h21;
            3'd1: b = 8'h41;
            3'd2: b = 8'h44;
            3'd3: b = 8'h43;
            default: b = 8'h3D;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] rts_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0: b = 8'h52;
            2'd1: b = 8'h54;
            default: b = 8'h53;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] ok_byte(input logic idx);
        logic [7:0] b;
        case (idx)
            1'b0: b = 8'h4F;
            default: b = 8'h4B;
        endcase
        return b;
    endfunction

    // Value of digit m at decimal place k.
    function automatic logic [13:0] digit_weight(input logic [1:0] k, input bcd_t m);
        logic [13:0] p;
        case (k)
            2'd0: p = 14'd1;
            2'd1: p = 14'd10;
            2'd2: p = 14'd100;
            default: p = 14'd1000;
        endcase
        return 14'(p * {10'd0, m});
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fcar_emitter.sv
`default_nettype none

module fcar_emitter
    import fcar_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire emit_req_t req,
    output logic           can_load,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [7:0]     tx_byte,
    output logic           last
);

    logic       busy_reg, busy_next;
    pos_t       pos_reg, pos_next;
    logic [2:0] nd_reg, nd_next;
    sample_t    rem_reg, rem_next;
    logic [1:0] conv_k_reg, conv_k_next;
    logic       conv_on_reg, conv_on_next;
    bcd_t       digit_reg [4];

    pos_t        msg_end;
    logic        fire;
    logic        done;
    bcd_t        step_digit;
    logic [13:0] step_sub;
    logic [2:0]  load_nd;
    logic [1:0]  out_k;

    assign msg_end = HEAD_LEN + {1'b0, nd_reg};
    assign fire = busy_reg && out_ready;
    assign done = fire && (pos_reg == msg_end);
    assign can_load = !busy_reg || done;

    always_comb
    begin
        if (req.sample >= 12'd1000)
        begin
            load_nd = 3'd4;
        end
        else if (req.sample >= 12'd100)
        begin
            load_nd = 3'd3;
        end
        else if (req.sample >= 12'd10)
        begin
            load_nd = 3'd2;
        end
        else
        begin
            load_nd = 3'd1;
        end
    end

    // One decimal digit per cycle, most significant first.
    always_comb
    begin
        step_digit = 4'd0;
        for (int m = 1; m < 10; m++)
        begin
            if ({2'b00, rem_reg} >= digit_weight(conv_k_reg, 4'(m)))
            begin
                step_digit = 4'(m);
            end
        end
        step_sub = digit_weight(conv_k_reg, step_digit);
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next = pos_reg;
        nd_next = nd_reg;
        rem_next = rem_reg;
        conv_k_next = conv_k_reg;
        conv_on_next = conv_on_reg;
        if (req.load)
        begin
            busy_next = 1'b1;
            pos_next = '0;
            nd_next = load_nd;
            rem_next = req.sample;
            conv_k_next = 2'd3;
            conv_on_next = 1'b1;
        end
        else
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            else if (fire)
            begin
                pos_next = pos_reg + 4'd1;
            end
            if (conv_on_reg)
            begin
                rem_next = rem_reg - step_sub[11:0];
                if (conv_k_reg == 2'd0)
                begin
                    conv_on_next = 1'b0;
                end
                else
                begin
                    conv_k_next = conv_k_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg <= '0;
            nd_reg <= 3'd1;
            conv_k_reg <= 2'd0;
            conv_on_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            pos_reg <= pos_next;
            nd_reg <= nd_next;
            conv_k_reg <= conv_k_next;
            conv_on_reg <= conv_on_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (!req.load && conv_on_reg)
        begin
            digit_reg[conv_k_reg] <= step_digit;
        end
    end

    assign out_k = 2'({1'b0, nd_reg} + 4'd4 - pos_reg);

    always_comb
    begin
        if (pos_reg < HEAD_LEN)
        begin
            tx_byte = head_byte(pos_reg[2:0]);
        end
        else if (pos_reg < msg_end)
        begin
            tx_byte = DIGIT_ZERO | {4'd0, digit_reg[out_k]};
        end
        else
        begin
            tx_byte = END_MARK;
        end
    end

    assign out_valid = busy_reg;
    assign last = busy_reg && (pos_reg == msg_end);

endmodule

`default_nettype wire

FILE: rtl/framed_command_adc_reply.sv
// Framed command decoder with a decimal ADC reply. Each input transaction is
// either a received byte or one timer tick and is decoded in the cycle after
// it is taken, so a new transaction is accepted every cycle while no reply is
// pending. A completed RTS frame, or a retry timeout while waiting for OK,
// starts the reply "!ADC=<n>#", sent as one output transaction per byte at up
// to one byte a cycle, seven to ten bytes in all. The reply sender holds one
// message; a transaction that starts a new reply waits until the closing '#'
// of the current one is taken. The retry interval is register 0 at address 0.

`default_nettype none

module framed_command_adc_reply
    import fcar_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [11:0] adc_sample,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tx_byte,
    output logic             last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] retry_ticks_reg;

    logic        item_valid_reg;
    logic        item_kind_reg;
    logic [7:0]  item_byte_reg;
    sample_t     item_sample_reg;

    logic        in_frame_reg, in_frame_next;
    logic [2:0]  frame_length_reg, frame_length_next;
    logic        match_rts_reg, match_rts_next;
    logic        match_ok_reg, match_ok_next;
    link_state_t link_state_reg, link_state_next;
    logic [15:0] retry_counter_reg, retry_counter_next;
    sample_t     latched_sample_reg, latched_sample_next;

    logic [15:0] limit;
    logic [15:0] counter_inc;
    logic        reply_tick;
    logic        reply_rts;
    logic        can_load;
    logic        item_done;
    emit_req_t   req;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RETRY_TICKS) ? {16'd0, retry_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_ticks_reg <= RETRY_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_RETRY_TICKS))
        begin
            retry_ticks_reg <= pwdata[15:0];
        end
    end

    assign limit = (retry_ticks_reg == 16'd0) ? 16'd1 : retry_ticks_reg;
    assign counter_inc = retry_counter_reg + 16'd1;

    always_comb
    begin
        reply_tick = 1'b0;
        reply_rts = 1'b0;
        if (item_valid_reg)
        begin
            if (item_kind_reg)
            begin
                reply_tick = (link_state_reg == LINK_WAIT_OK) && (counter_inc >= limit);
            end
            else
            begin
                reply_rts = in_frame_reg && (item_byte_reg == END_MARK)
                    && (link_state_reg == LINK_IDLE) && match_rts_reg
                    && (frame_length_reg == 3'd3);
            end
        end
    end

    assign item_done = item_valid_reg && (!(reply_tick || reply_rts) || can_load);
    assign in_ready = !item_valid_reg || item_done;
    assign req.load = item_valid_reg && (reply_tick || reply_rts) && can_load;
    assign req.sample = reply_rts ? item_sample_reg : latched_sample_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        frame_length_next = frame_length_reg;
        match_rts_next = match_rts_reg;
        match_ok_next = match_ok_reg;
        link_state_next = link_state_reg;
        retry_counter_next = retry_counter_reg;
        latched_sample_next = latched_sample_reg;
        if (item_kind_reg)
        begin
            if (link_state_reg == LINK_WAIT_OK)
            begin
                retry_counter_next = reply_tick ? 16'd0 : counter_inc;
            end
        end
        else if (!in_frame_reg)
        begin
            if (item_byte_reg == START_MARK)
            begin
                in_frame_next = 1'b1;
                frame_length_next = 3'd0;
                match_rts_next = 1'b1;
                match_ok_next = 1'b1;
            end
        end
        else if (item_byte_reg != END_MARK)
        begin
            if ((frame_length_reg >= 3'd3) || (item_byte_reg != rts_byte(frame_length_reg[1:0])))
            begin
                match_rts_next = 1'b0;
            end
            if ((frame_length_reg >= 3'd2) || (item_byte_reg != ok_byte(frame_length_reg[0])))
            begin
                match_ok_next = 1'b0;
            end
            if (frame_length_reg < LEN_SAT)
            begin
                frame_length_next = frame_length_reg + 3'd1;
            end
        end
        else
        begin
            in_frame_next = 1'b0;
            if (reply_rts)
            begin
                latched_sample_next = item_sample_reg;
                link_state_next = LINK_WAIT_OK;
                retry_counter_next = 16'd0;
            end
            else if ((link_state_reg == LINK_WAIT_OK) && match_ok_reg
                && (frame_length_reg == 3'd2))
            begin
                link_state_next = LINK_IDLE;
                retry_counter_next = 16'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            in_frame_reg <= 1'b0;
            frame_length_reg <= 3'd0;
            match_rts_reg <= 1'b1;
            match_ok_reg <= 1'b1;
            link_state_reg <= LINK_IDLE;
            retry_counter_reg <= 16'd0;
            latched_sample_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
            if (item_done)
            begin
                in_frame_reg <= in_frame_next;
                frame_length_reg <= frame_length_next;
                match_rts_reg <= match_rts_next;
                match_ok_reg <= match_ok_next;
                link_state_reg <= link_state_next;
                retry_counter_reg <= retry_counter_next;
                latched_sample_reg <= latched_sample_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_kind_reg <= kind;
            item_byte_reg <= rx_byte;
            item_sample_reg <= adc_sample;
        end
    end

    fcar_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tx_byte   (tx_byte),
        .last      (last)
    );

endmodule

`default_nettype wire
